FILE: rtl/bpfc_pkg.sv
// Shared widths, angle constants, arctangent table and saturation for the foot correction block.
`timescale 1ns / 1ps
package bpfc_pkg;

   localparam int TW = 19;   // foot totals
   localparam int AW = 19;   // yaw work width
   localparam int VW = 33;   // CORDIC x/y
   localparam int ZW = 26;   // CORDIC angle, Q16 degrees
   localparam int MW = 50;   // total * gain
   localparam int PW = 52;   // total * sine
   localparam int DW = 60;   // divider numerator
   localparam int QB = 28;   // quotient bits of one tangent term
   localparam int OW = 21;   // result fields
   localparam int CW = 24;   // pre-saturation results

   localparam int ATAN_LEN   = 24;
   localparam int DEG90      = 23040;
   localparam int DEG180     = 46080;
   localparam int DEG360     = 92160;
   localparam int TILT_LIMIT = 15360;
   localparam int OUT_MAX    = 1048575;
   localparam int OUT_MIN    = -1048576;

   localparam logic signed [MW-1:0] GAIN_Q30 = MW'(652032874);

   // atan(2^-i) in Q16 degrees
   function automatic logic signed [ZW-1:0] atan_q16(input int idx);
      logic signed [ZW-1:0] a;
      a = '0;
      unique case (idx)
         0:  a = ZW'(2949120);
         1:  a = ZW'(1740967);
         2:  a = ZW'(919879);
         3:  a = ZW'(466945);
         4:  a = ZW'(234379);
         5:  a = ZW'(117304);
         6:  a = ZW'(58666);
         7:  a = ZW'(29335);
         8:  a = ZW'(14668);
         9:  a = ZW'(7334);
         10: a = ZW'(3667);
         11: a = ZW'(1833);
         12: a = ZW'(917);
         13: a = ZW'(458);
         14: a = ZW'(229);
         15: a = ZW'(115);
         16: a = ZW'(57);
         17: a = ZW'(29);
         18: a = ZW'(14);
         19: a = ZW'(7);
         20: a = ZW'(4);
         21: a = ZW'(2);
         22: a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [OW-1:0] sat_out(input logic signed [CW-1:0] v);
      logic signed [OW-1:0] r;
      r = v[OW-1:0];
      if (v > CW'(OUT_MAX)) begin
         r = OW'(OUT_MAX);
      end else if (v < CW'(OUT_MIN)) begin
         r = OW'(OUT_MIN);
      end
      return r;
   endfunction

endpackage

FILE: rtl/body_pose_foot_correction.sv
// Per-leg body pose correction: yaw rotation of the foot and roll/pitch height correction.
// Fully pipelined: one transaction may enter every clock while the pipe is not stalled
// (three input stages, one CORDIC micro-rotation per stage, a product stage P and a
// magnitude stage Q, one restoring-divider bit per stage for the 28-bit tangent
// quotients, one output register). A stalled result register freezes the whole pipe,
// so req_ready is low exactly while a result waits and rsp_ready is low.
`timescale 1ns / 1ps
module body_pose_foot_correction #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [16:0]              req_foot_x,
   input  logic signed [16:0]              req_foot_y,
   input  logic signed [16:0]              req_center_offset_x,
   input  logic signed [16:0]              req_center_offset_y,
   input  logic signed [16:0]              req_shift_x,
   input  logic signed [16:0]              req_shift_y,
   input  logic signed [14:0]              req_pitch_deg,
   input  logic signed [16:0]              req_yaw_deg,
   input  logic signed [14:0]              req_roll_deg,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [bpfc_pkg::OW-1:0]  rsp_correction_x,
   output logic signed [bpfc_pkg::OW-1:0]  rsp_correction_y,
   output logic signed [bpfc_pkg::OW-1:0]  rsp_correction_z
);

   localparam int TW = bpfc_pkg::TW;
   localparam int AW = bpfc_pkg::AW;
   localparam int VW = bpfc_pkg::VW;
   localparam int ZW = bpfc_pkg::ZW;
   localparam int MW = bpfc_pkg::MW;
   localparam int PW = bpfc_pkg::PW;
   localparam int DW = bpfc_pkg::DW;
   localparam int QB = bpfc_pkg::QB;
   localparam int OW = bpfc_pkg::OW;
   localparam int CW = bpfc_pkg::CW;
   localparam int NS = (CORDIC_STAGES > bpfc_pkg::ATAN_LEN) ?
                       bpfc_pkg::ATAN_LEN : CORDIC_STAGES;
   localparam int SW = QB + 3;

   logic en;

   // ---------------- stage A: totals, angle wrap and clamps
   logic                 a_v_ff;
   logic signed [TW-1:0] a_tx_ff, a_ty_ff;
   logic signed [ZW-1:0] a_yz_ff, a_rz_ff, a_pz_ff;
   logic                 a_fold_ff;

   logic signed [TW-1:0] tx_in, ty_in;
   logic signed [AW-1:0] yw_in, yf_in;
   logic                 fold_in;
   logic signed [14:0]   rc_in, pc_in;

   always_comb begin
      tx_in = TW'(req_foot_x) + TW'(req_center_offset_x) + TW'(req_shift_x);
      ty_in = TW'(req_foot_y) + TW'(req_center_offset_y) + TW'(req_shift_y);
      yw_in = AW'(req_yaw_deg);
      if (yw_in >= AW'(bpfc_pkg::DEG180)) begin
         yw_in = yw_in - AW'(bpfc_pkg::DEG360);
      end else if (yw_in < -AW'(bpfc_pkg::DEG180)) begin
         yw_in = yw_in + AW'(bpfc_pkg::DEG360);
      end
      // beyond a quarter turn: turn the other way and flip the vector
      fold_in = 1'b0;
      yf_in   = yw_in;
      if (yw_in > AW'(bpfc_pkg::DEG90)) begin
         yf_in   = yw_in - AW'(bpfc_pkg::DEG180);
         fold_in = 1'b1;
      end else if (yw_in < -AW'(bpfc_pkg::DEG90)) begin
         yf_in   = yw_in + AW'(bpfc_pkg::DEG180);
         fold_in = 1'b1;
      end
      rc_in = req_roll_deg;
      if (req_roll_deg > 15'(bpfc_pkg::TILT_LIMIT)) begin
         rc_in = 15'(bpfc_pkg::TILT_LIMIT);
      end else if (req_roll_deg < -15'(bpfc_pkg::TILT_LIMIT)) begin
         rc_in = -15'(bpfc_pkg::TILT_LIMIT);
      end
      pc_in = req_pitch_deg;
      if (req_pitch_deg > 15'(bpfc_pkg::TILT_LIMIT)) begin
         pc_in = 15'(bpfc_pkg::TILT_LIMIT);
      end else if (req_pitch_deg < -15'(bpfc_pkg::TILT_LIMIT)) begin
         pc_in = -15'(bpfc_pkg::TILT_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_tx_ff   <= tx_in;
         a_ty_ff   <= ty_in;
         a_fold_ff <= fold_in;
         a_yz_ff   <= ZW'(yf_in) <<< 8;
         a_rz_ff   <= ZW'(rc_in) <<< 8;
         a_pz_ff   <= ZW'(pc_in) <<< 8;
      end
   end

   // ---------------- stage B: gain prescale
   logic                 b_v_ff;
   logic signed [MW-1:0] b_mx_ff, b_my_ff;
   logic signed [TW-1:0] b_tx_ff, b_ty_ff;
   logic signed [ZW-1:0] b_yz_ff, b_rz_ff, b_pz_ff;
   logic                 b_fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_mx_ff   <= MW'(a_tx_ff) * bpfc_pkg::GAIN_Q30;
         b_my_ff   <= MW'(a_ty_ff) * bpfc_pkg::GAIN_Q30;
         b_tx_ff   <= a_tx_ff;
         b_ty_ff   <= a_ty_ff;
         b_yz_ff   <= a_yz_ff;
         b_rz_ff   <= a_rz_ff;
         b_pz_ff   <= a_pz_ff;
         b_fold_ff <= a_fold_ff;
      end
   end

   // ---------------- stage C and CORDIC pipe (index 0 is stage C)
   logic                 cv_ff  [0:NS];
   logic signed [VW-1:0] yx_ff  [0:NS];
   logic signed [VW-1:0] yy_ff  [0:NS];
   logic signed [ZW-1:0] yz_ff  [0:NS];
   logic signed [VW-1:0] rc_ff  [0:NS];
   logic signed [VW-1:0] rs_ff  [0:NS];
   logic signed [ZW-1:0] rz_ff  [0:NS];
   logic signed [VW-1:0] pc_ff  [0:NS];
   logic signed [VW-1:0] ps_ff  [0:NS];
   logic signed [ZW-1:0] pz_ff  [0:NS];
   logic signed [TW-1:0] ctx_ff [0:NS];
   logic signed [TW-1:0] cty_ff [0:NS];

   logic signed [VW-1:0] vx_in, vy_in;

   always_comb begin
      vx_in = VW'((b_mx_ff + (MW'(1) <<< 17)) >>> 18);
      vy_in = VW'((b_my_ff + (MW'(1) <<< 17)) >>> 18);
      if (b_fold_ff) begin
         vx_in = -vx_in;
         vy_in = -vy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         cv_ff[0] <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yx_ff[0]  <= vx_in;
         yy_ff[0]  <= vy_in;
         yz_ff[0]  <= b_yz_ff;
         rc_ff[0]  <= VW'(1) <<< 30;
         rs_ff[0]  <= '0;
         rz_ff[0]  <= b_rz_ff;
         pc_ff[0]  <= VW'(1) <<< 30;
         ps_ff[0]  <= '0;
         pz_ff[0]  <= b_pz_ff;
         ctx_ff[0] <= b_tx_ff;
         cty_ff[0] <= b_ty_ff;
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      logic signed [ZW-1:0] ang;
      assign ang = bpfc_pkg::atan_q16(i);

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctx_ff[i+1] <= ctx_ff[i];
            cty_ff[i+1] <= cty_ff[i];
            if (!yz_ff[i][ZW-1]) begin
               yx_ff[i+1] <= yx_ff[i] - (yy_ff[i] >>> i);
               yy_ff[i+1] <= yy_ff[i] + (yx_ff[i] >>> i);
               yz_ff[i+1] <= yz_ff[i] - ang;
            end else begin
               yx_ff[i+1] <= yx_ff[i] + (yy_ff[i] >>> i);
               yy_ff[i+1] <= yy_ff[i] - (yx_ff[i] >>> i);
               yz_ff[i+1] <= yz_ff[i] + ang;
            end
            if (!rz_ff[i][ZW-1]) begin
               rc_ff[i+1] <= rc_ff[i] - (rs_ff[i] >>> i);
               rs_ff[i+1] <= rs_ff[i] + (rc_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] - ang;
            end else begin
               rc_ff[i+1] <= rc_ff[i] + (rs_ff[i] >>> i);
               rs_ff[i+1] <= rs_ff[i] - (rc_ff[i] >>> i);
               rz_ff[i+1] <= rz_ff[i] + ang;
            end
            if (!pz_ff[i][ZW-1]) begin
               pc_ff[i+1] <= pc_ff[i] - (ps_ff[i] >>> i);
               ps_ff[i+1] <= ps_ff[i] + (pc_ff[i] >>> i);
               pz_ff[i+1] <= pz_ff[i] - ang;
            end else begin
               pc_ff[i+1] <= pc_ff[i] + (ps_ff[i] >>> i);
               ps_ff[i+1] <= ps_ff[i] - (pc_ff[i] >>> i);
               pz_ff[i+1] <= pz_ff[i] + ang;
            end
         end
      end
   end

   // ---------------- stage P: X/Y corrections, tangent numerator products
   logic                   p_v_ff;
   logic signed [OW-1:0]   p_cx_ff, p_cy_ff;
   logic signed [PW-1:0]   p_pr_ff, p_pp_ff;
   logic [VW-2:0]          p_dr_ff, p_dp_ff;

   logic signed [VW-1:0]   rx_w, ry_w;
   logic signed [VW-2:0]   dr_w, dp_w;

   always_comb begin
      rx_w = (yx_ff[NS] + VW'(2048)) >>> 12;
      ry_w = (yy_ff[NS] + VW'(2048)) >>> 12;
      // a nonpositive cosine is taken as one
      dr_w = (rc_ff[NS] <= 0) ? (VW-1)'(1) : rc_ff[NS][VW-2:0];
      dp_w = (pc_ff[NS] <= 0) ? (VW-1)'(1) : pc_ff[NS][VW-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (en) begin
         p_v_ff <= cv_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_cx_ff <= bpfc_pkg::sat_out(CW'(rx_w) - CW'(ctx_ff[NS]));
         p_cy_ff <= bpfc_pkg::sat_out(CW'(ry_w) - CW'(cty_ff[NS]));
         p_pr_ff <= PW'(ctx_ff[NS]) * PW'(rs_ff[NS]);
         p_pp_ff <= PW'(cty_ff[NS]) * PW'(ps_ff[NS]);
         p_dr_ff <= dr_w;
         p_dp_ff <= dp_w;
      end
   end

   // ---------------- stage Q and divider pipe (index 0 is stage Q)
   logic                 dv_ff  [0:QB];
   logic [DW-1:0]        rr_ff  [0:QB];
   logic [DW-1:0]        rp_ff  [0:QB];
   logic [QB-1:0]        qr_ff  [0:QB];
   logic [QB-1:0]        qp_ff  [0:QB];
   logic [VW-2:0]        dr_ff  [0:QB];
   logic [VW-2:0]        dp_ff  [0:QB];
   logic                 nr_ff  [0:QB];
   logic                 np_ff  [0:QB];
   logic signed [OW-1:0] dcx_ff [0:QB];
   logic signed [OW-1:0] dcy_ff [0:QB];

   logic signed [DW-1:0] numr_w, nump_w;

   assign numr_w = DW'(p_pr_ff) <<< 8;
   assign nump_w = DW'(p_pp_ff) <<< 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff[0]  <= numr_w[DW-1] ? DW'(-numr_w) : DW'(numr_w);
         rp_ff[0]  <= nump_w[DW-1] ? DW'(-nump_w) : DW'(nump_w);
         nr_ff[0]  <= numr_w[DW-1];
         np_ff[0]  <= nump_w[DW-1];
         qr_ff[0]  <= '0;
         qp_ff[0]  <= '0;
         dr_ff[0]  <= p_dr_ff;
         dp_ff[0]  <= p_dp_ff;
         dcx_ff[0] <= p_cx_ff;
         dcy_ff[0] <= p_cy_ff;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int SH = QB - 1 - k;
      logic [DW-1:0] tr_w, tp_w;
      logic          br_w, bp_w;

      assign tr_w = DW'(dr_ff[k]) << SH;
      assign tp_w = DW'(dp_ff[k]) << SH;
      assign br_w = (rr_ff[k] >= tr_w);
      assign bp_w = (rp_ff[k] >= tp_w);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rr_ff[k+1]  <= br_w ? (rr_ff[k] - tr_w) : rr_ff[k];
            rp_ff[k+1]  <= bp_w ? (rp_ff[k] - tp_w) : rp_ff[k];
            qr_ff[k+1]  <= {qr_ff[k][QB-2:0], br_w};
            qp_ff[k+1]  <= {qp_ff[k][QB-2:0], bp_w};
            dr_ff[k+1]  <= dr_ff[k];
            dp_ff[k+1]  <= dp_ff[k];
            nr_ff[k+1]  <= nr_ff[k];
            np_ff[k+1]  <= np_ff[k];
            dcx_ff[k+1] <= dcx_ff[k];
            dcy_ff[k+1] <= dcy_ff[k];
         end
      end
   end

   // ---------------- output register: signed terms, Z rounding
   logic                 o_v_ff;
   logic signed [OW-1:0] o_cx_ff, o_cy_ff, o_cz_ff;

   logic signed [QB:0]   tqr_w, tqp_w;
   logic signed [SW-1:0] zsum_w;

   always_comb begin
      tqr_w  = $signed({1'b0, qr_ff[QB]});
      tqp_w  = $signed({1'b0, qp_ff[QB]});
      if (nr_ff[QB]) begin
         tqr_w = -tqr_w;
      end
      if (np_ff[QB]) begin
         tqp_w = -tqp_w;
      end
      zsum_w = (SW'(tqr_w) + SW'(tqp_w) + SW'(128)) >>> 8;
   end

   assign en = !o_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= dv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_cx_ff <= dcx_ff[QB];
         o_cy_ff <= dcy_ff[QB];
         o_cz_ff <= bpfc_pkg::sat_out(CW'(zsum_w));
      end
   end

   assign req_ready        = en;
   assign rsp_valid        = o_v_ff;
   assign rsp_correction_x = o_cx_ff;
   assign rsp_correction_y = o_cy_ff;
   assign rsp_correction_z = o_cz_ff;

endmodule

FILE: rtl/bpfc_checker.sv
// Port-level checks for the foot correction block and their bind.
`timescale 1ns / 1ps
module bpfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [bpfc_pkg::OW-1:0]  rsp_correction_x,
   input logic signed [bpfc_pkg::OW-1:0]  rsp_correction_y,
   input logic signed [bpfc_pkg::OW-1:0]  rsp_correction_z
);

   // no result survives reset
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // pipe advances exactly when the result register can move
   a_ready_tracks_out : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow result stall");

   // a stalled result transaction holds its value
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_correction_x)
         && $stable(rsp_correction_y) && $stable(rsp_correction_z))
      else $error("stalled result changed");

endmodule

bind body_pose_foot_correction bpfc_checker u_bpfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_correction_x (rsp_correction_x),
   .rsp_correction_y (rsp_correction_y),
   .rsp_correction_z (rsp_correction_z)
);

FILE: test/testbench.sv
// Self-checking testbench for the per-leg body pose foot correction block.
`timescale 1ns / 1ps
module testbench;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 34;

   typedef struct packed {
      logic signed [16:0] fx, fy, ox, oy, sx, sy;
      logic signed [14:0] pitch;
      logic signed [16:0] yaw;
      logic signed [14:0] roll;
   } pose_type;

   typedef struct packed {
      logic signed [bpfc_pkg::OW-1:0] cx, cy, cz;
   } corr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [16:0] req_foot_x = '0, req_foot_y = '0;
   logic signed [16:0] req_center_offset_x = '0, req_center_offset_y = '0;
   logic signed [16:0] req_shift_x = '0, req_shift_y = '0;
   logic signed [14:0] req_pitch_deg = '0, req_roll_deg = '0;
   logic signed [16:0] req_yaw_deg = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [bpfc_pkg::OW-1:0] rsp_correction_x, rsp_correction_y, rsp_correction_z;

   body_pose_foot_correction #(.CORDIC_STAGES(STAGES)) dut (.*);

   always #5 clock = ~clock;

   pose_type pending_poses[$];
   corr_type expected_corrs[$];
   int mismatches = 0;
   bit stim_done = 0;
   int hold_until_drained = -1;
   int sent = 0;
   bit req_taken = 1'b0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_out(longint v);
      if (v > bpfc_pkg::OUT_MAX) return bpfc_pkg::OUT_MAX;
      if (v < bpfc_pkg::OUT_MIN) return bpfc_pkg::OUT_MIN;
      return v;
   endfunction

   function automatic longint arctan_entry(int i);
      longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      return tbl[i];
   endfunction

   function automatic void rotate_vec(inout longint x, inout longint y, input longint z);
      longint dx, dy;
      for (int i = 0; i < (STAGES > 24 ? 24 : STAGES); i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_entry(i);
         end else begin
            x += dx; y -= dy; z += arctan_entry(i);
         end
      end
   endfunction

   function automatic longint tilt_term(longint total, longint ang);
      longint c, s;
      c = 64'sd1 <<< 30;
      s = 0;
      if (ang > bpfc_pkg::TILT_LIMIT) ang = bpfc_pkg::TILT_LIMIT;
      if (ang < -bpfc_pkg::TILT_LIMIT) ang = -bpfc_pkg::TILT_LIMIT;
      rotate_vec(c, s, ang * 256);
      if (c <= 0) c = 1;
      return (total * s * 256) / c;
   endfunction

   function automatic corr_type predict_correction(pose_type p);
      longint tx, ty, yaw, vx, vy, cx, cy, cz;
      corr_type r;
      tx = longint'(p.fx) + longint'(p.ox) + longint'(p.sx);
      ty = longint'(p.fy) + longint'(p.oy) + longint'(p.sy);
      yaw = p.yaw;
      vx = floor_shift(tx * 652032874 + (64'sd1 <<< 17), 18);
      vy = floor_shift(ty * 652032874 + (64'sd1 <<< 17), 18);
      if (yaw >= bpfc_pkg::DEG180) yaw -= bpfc_pkg::DEG360;
      if (yaw < -bpfc_pkg::DEG180) yaw += bpfc_pkg::DEG360;
      if (yaw > bpfc_pkg::DEG90) begin
         yaw -= bpfc_pkg::DEG180; vx = -vx; vy = -vy;
      end else if (yaw < -bpfc_pkg::DEG90) begin
         yaw += bpfc_pkg::DEG180; vx = -vx; vy = -vy;
      end
      rotate_vec(vx, vy, yaw * 256);
      cx = floor_shift(vx + 2048, 12) - tx;
      cy = floor_shift(vy + 2048, 12) - ty;
      cz = floor_shift(tilt_term(tx, p.roll) + tilt_term(ty, p.pitch) + 128, 8);
      r.cx = bpfc_pkg::OW'(clamp_out(cx));
      r.cy = bpfc_pkg::OW'(clamp_out(cy));
      r.cz = bpfc_pkg::OW'(clamp_out(cz));
      return r;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [16:0] rand_coord();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 17'h0FFFF;
      if (k == 1) return 17'h10000;
      if (k < 5) return 17'($signed($urandom_range(0, 8000)) - 4000);
      return 17'($urandom);
   endfunction

   function automatic logic [14:0] rand_tilt();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 15'($urandom);
      if (k == 1) return $urandom_range(0, 1) ? 15'sd15360 : -15'sd15360;
      return 15'($urandom_range(0, 30720) - 15360);
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      p.fx = rand_coord(); p.fy = rand_coord();
      p.ox = rand_coord(); p.oy = rand_coord();
      p.sx = rand_coord(); p.sy = rand_coord();
      p.pitch = rand_tilt(); p.roll = rand_tilt();
      p.yaw = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 92160) - 46080);
      return p;
   endfunction

   initial begin
      pose_type p;
      logic signed [16:0] yaws[8] = '{0, 23040, -23040, 23041, -23041, 46079, -46080, 65535};
      logic signed [14:0] tilts[6] = '{0, 15360, -15360, 16383, -16384, 256};
      // directed: extreme coordinates, yaw quadrant edges, tilt clamps
      p = '0;
      foreach (yaws[i]) begin
         p = '{17'sd1000, -17'sd2000, 17'sd300, 17'sd400, -17'sd50, 17'sd60,
               15'sd0, yaws[i], 15'sd0};
         pending_poses.push_back(p);
      end
      foreach (tilts[i]) begin
         p = '{17'sd5000, 17'sd7000, 17'sd0, 17'sd0, 17'sd0, 17'sd0,
               tilts[i], 17'sd5000, tilts[5 - i]};
         pending_poses.push_back(p);
      end
      p = '{17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h0FFFF,
            15'sd15360, 17'sd11520, 15'sd15360};
      pending_poses.push_back(p);
      p = '{17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000, 17'h10000,
            -15'sd15360, -17'sd46080, -15'sd15360};
      pending_poses.push_back(p);
      p = '{17'h0FFFF, 17'h10000, 17'h0FFFF, 17'h10000, 17'h0FFFF, 17'h10000,
            15'sd15360, 17'sd23040, -15'sd15360};
      pending_poses.push_back(p);
      pending_poses.push_back('0);
      hold_until_drained = pending_poses.size();
      repeat (1900) pending_poses.push_back(rand_pose());
   end

   // transaction taken at the last rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
   end

   // driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold payload until accepted
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (sent == hold_until_drained && expected_corrs.size() != 0) begin
         req_valid <= 1'b0;
      end else if (pending_poses.size() != 0) begin
         pose_type p;
         p = pending_poses.pop_front();
         req_valid <= 1'b1;
         {req_foot_x, req_foot_y, req_center_offset_x, req_center_offset_y,
          req_shift_x, req_shift_y, req_pitch_deg, req_yaw_deg, req_roll_deg} <= p;
         req_gap <= gap_len();
      end else begin
         req_valid <= 1'b0;
         stim_done <= 1'b1;
      end
   end

   int rsp_gap = 0;
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap <= gap_len();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_corrs.push_back(predict_correction(
               {req_foot_x, req_foot_y, req_center_offset_x, req_center_offset_y,
                req_shift_x, req_shift_y, req_pitch_deg, req_yaw_deg, req_roll_deg}));
            sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_corrs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction at %0t", $time);
            end else begin
               corr_type e;
               e = expected_corrs.pop_front();
               if (e.cx !== rsp_correction_x || e.cy !== rsp_correction_y ||
                   e.cz !== rsp_correction_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at %0t: exp %0d %0d %0d got %0d %0d %0d", $time,
                              e.cx, e.cy, e.cz, rsp_correction_x, rsp_correction_y,
                              rsp_correction_z);
               end
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_corrs.size() == 0);
      repeat (LATENCY * 2) @(posedge clock);
      if (mismatches == 0 && expected_corrs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
